// ===== sv/dtc_pkg.sv =====
// dtc_pkg: shared types and constants of the debounced tally counter
// used by every module of the block; depends on nothing

package dtc_pkg;

    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TIME = 2'd0,
        CFG_SLEEP_TIMEOUT = 2'd1,
        CFG_COUNT_LIMIT   = 2'd2
    } cfg_index_t;

    // opcode of an input item
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_INIT   = 1'b1;

    // reset values of the configuration registers
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_DATA_W-1:0] SLEEP_RESET    = 32'd30000;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET    = 32'd9999;

    typedef struct packed {
        logic        opcode;
        logic        inc_raw;
        logic        rst_raw;
        logic [31:0] now_time;
        logic [31:0] saved_count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        overflow_flag;
        logic        dirty_flag;
        logic        awake_flag;
        logic        inc_level;
        logic        rst_level;
    } out_item_t;

    // debouncer status toward the tally logic
    typedef struct packed {
        logic press;   // qualified press on this item
        logic level;   // stable level after this item
    } deb_status_t;

endpackage

// ===== sv/dtc_debounce.sv =====
// dtc_debounce: timestamp debouncer for one button
// depends on dtc_pkg

module dtc_debounce #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            init,
    input  logic                            raw,
    input  logic [TIME_WIDTH-1:0]           now_t,
    input  logic [dtc_pkg::DEBOUNCE_W-1:0]  debounce_time,
    output dtc_pkg::deb_status_t            status
);

    localparam int unsigned CMP_W =
        (TIME_WIDTH > dtc_pkg::DEBOUNCE_W) ? TIME_WIDTH : dtc_pkg::DEBOUNCE_W;

    logic                  cand_reg;
    logic                  stable_reg;
    logic [TIME_WIDTH-1:0] since_reg;

    logic [TIME_WIDTH-1:0] since_next;
    logic [TIME_WIDTH-1:0] held;
    logic                  hold_ok;
    logic                  flip;
    logic                  stable_next;

    // a new raw level restarts the hold time
    assign since_next  = (raw != cand_reg) ? now_t : since_reg;
    assign held        = now_t - since_next;
    assign hold_ok     = CMP_W'(held) >= CMP_W'(debounce_time);
    assign flip        = (stable_reg != raw) && hold_ok;
    assign stable_next = flip ? raw : stable_reg;

    assign status.press = flip && raw;
    assign status.level = stable_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg   <= 1'b0;
            stable_reg <= 1'b0;
            since_reg  <= '0;
        end else if (init) begin
            cand_reg   <= 1'b0;
            stable_reg <= 1'b0;
            since_reg  <= now_t;
        end else if (step) begin
            cand_reg   <= raw;
            stable_reg <= stable_next;
            since_reg  <= since_next;
        end
    end

endmodule

// ===== sv/debounced_tally_counter.sv =====
// debounced_tally_counter: top level of the two-button tally counter
// depends on dtc_pkg and dtc_debounce
//
// usage
//   s_valid/s_ready/s_item carry one item per sample: an opcode, raw levels
//   of the increment and reset buttons, a timestamp and a saved count.
//   each accepted item yields exactly one result item on m_valid/m_ready/
//   m_item: the tally, overflow, dirty and awake flags and both debounced
//   button levels after that item.
//   cfg_wr_en/cfg_index/cfg_wdata write debounce time, sleep timeout and
//   count limit; write them only while no item is in flight.
// throughput
//   the result is registered, in the skid register while the main entry is held.
//   one item per cycle is taken as long as results are taken at that rate;
//   all of an item's work is one pass of compare and add logic into state.
// stall
//   a two-entry output buffer (result register plus skid register) lets one
//   more item in while the receiver holds off; s_ready drops only while both
//   entries are full.
// reset
//   aresetn low clears the tally, flags and debouncers, sets awake, loads the
//   default configuration (20, 30000, 9999) and empties the output buffer.

module debounced_tally_counter #(
    parameter int unsigned TIME_WIDTH  = 32,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dtc_pkg::in_item_t                s_item,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output dtc_pkg::out_item_t               m_item,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int unsigned SLEEP_CMP_W =
        (TIME_WIDTH > dtc_pkg::CFG_DATA_W) ? TIME_WIDTH : dtc_pkg::CFG_DATA_W;

    // configuration
    logic [dtc_pkg::DEBOUNCE_W-1:0] debounce_time_reg;
    logic [dtc_pkg::CFG_DATA_W-1:0] sleep_timeout_reg;
    logic [dtc_pkg::CFG_DATA_W-1:0] count_limit_reg;

    // counter state
    logic [COUNT_WIDTH-1:0] tally_reg, tally_next;
    logic                   overflow_reg, overflow_next;
    logic                   dirty_reg, dirty_next;
    logic                   awake_reg, awake_next;
    logic [TIME_WIDTH-1:0]  last_press_reg, last_press_next;

    // output buffer
    logic                 main_valid_reg, skid_valid_reg;
    dtc_pkg::out_item_t   main_reg, skid_reg;
    dtc_pkg::out_item_t   result;

    logic                  push, pop;
    logic                  do_init, do_sample;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] idle_time;
    logic [COUNT_WIDTH-1:0] limit;
    logic                  limit_clipped;
    dtc_pkg::deb_status_t  inc_st, rst_st;

    assign s_ready   = !skid_valid_reg;
    assign push      = s_valid && s_ready;
    assign pop       = main_valid_reg && m_ready;
    assign do_init   = push && (s_item.opcode == dtc_pkg::OP_INIT);
    assign do_sample = push && (s_item.opcode == dtc_pkg::OP_SAMPLE);

    // timestamps live at TIME_WIDTH, differences wrap there
    assign now_t = TIME_WIDTH'(s_item.now_time);

    // limit saturated to the widest tally value
    assign limit_clipped = (count_limit_reg >> COUNT_WIDTH) != '0;
    assign limit         = limit_clipped ? '1 : COUNT_WIDTH'(count_limit_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= dtc_pkg::DEBOUNCE_RESET;
            sleep_timeout_reg <= dtc_pkg::SLEEP_RESET;
            count_limit_reg   <= dtc_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dtc_pkg::CFG_DEBOUNCE_TIME: begin
                    debounce_time_reg <= cfg_wdata[dtc_pkg::DEBOUNCE_W-1:0];
                end
                dtc_pkg::CFG_SLEEP_TIMEOUT: begin
                    sleep_timeout_reg <= cfg_wdata;
                end
                dtc_pkg::CFG_COUNT_LIMIT: begin
                    count_limit_reg <= cfg_wdata;
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // one debouncer per button
    dtc_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_inc_deb (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (do_sample),
        .init          (do_init),
        .raw           (s_item.inc_raw),
        .now_t         (now_t),
        .debounce_time (debounce_time_reg),
        .status        (inc_st)
    );

    dtc_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_rst_deb (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (do_sample),
        .init          (do_init),
        .raw           (s_item.rst_raw),
        .now_t         (now_t),
        .debounce_time (debounce_time_reg),
        .status        (rst_st)
    );

    // tally update for one item
    always_comb begin
        tally_next      = tally_reg;
        overflow_next   = overflow_reg;
        dirty_next      = dirty_reg;
        awake_next      = awake_reg;
        last_press_next = last_press_reg;
        idle_time       = '0;
        if (s_item.opcode == dtc_pkg::OP_INIT) begin
            // saved count restored, or zero when it is beyond the limit
            tally_next      = (s_item.saved_count <= 32'(limit))
                              ? COUNT_WIDTH'(s_item.saved_count) : '0;
            overflow_next   = 1'b0;
            dirty_next      = 1'b0;
            awake_next      = 1'b1;
            last_press_next = now_t;
        end else begin
            if (inc_st.press || rst_st.press) begin
                awake_next      = 1'b1;
                last_press_next = now_t;
                if (rst_st.press) begin
                    // reset wins over a simultaneous increment
                    tally_next    = '0;
                    overflow_next = 1'b0;
                    dirty_next    = 1'b1;
                end else if (!rst_st.level) begin
                    if (tally_reg < limit) begin
                        tally_next = tally_reg + COUNT_WIDTH'(1);
                        dirty_next = 1'b1;
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
            end
            // sleep check after any press of this item
            idle_time = now_t - last_press_next;
            if (SLEEP_CMP_W'(idle_time) >= SLEEP_CMP_W'(sleep_timeout_reg)) begin
                awake_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg      <= '0;
            overflow_reg   <= 1'b0;
            dirty_reg      <= 1'b0;
            awake_reg      <= 1'b1;
            last_press_reg <= '0;
        end else if (push) begin
            tally_reg      <= tally_next;
            overflow_reg   <= overflow_next;
            dirty_reg      <= dirty_next;
            awake_reg      <= awake_next;
            last_press_reg <= last_press_next;
        end
    end

    // result item as seen after this item
    always_comb begin
        result.count_value   = 32'(tally_next);
        result.overflow_flag = overflow_next;
        result.dirty_flag    = dirty_next;
        result.awake_flag    = awake_next;
        // init clears both debouncers, so both levels read low
        result.inc_level     = (s_item.opcode == dtc_pkg::OP_INIT) ? 1'b0 : inc_st.level;
        result.rst_level     = (s_item.opcode == dtc_pkg::OP_INIT) ? 1'b0 : rst_st.level;
    end

    // two-entry output buffer: skid fills only when the result register is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= result;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_reg <= result;
            end else begin
                main_reg <= result;
            end
        end
    end

    assign m_valid = main_valid_reg;
    assign m_item  = main_reg;

endmodule

// ===== sv/dtc_checker.sv =====
// dtc_checker: port-level assertions for the debounced tally counter
// depends on dtc_pkg; bound to debounced_tally_counter below

module dtc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input dtc_pkg::out_item_t m_item
);

    // a held result stays put until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // input side blocks only when a result is waiting
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result pending");

    // an item taken behind a stalled result fills the skid entry
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> !s_ready)
        else $error("second buffered item not reflected in s_ready");

    // an accepted item always leaves a result behind it
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item produced no result");

    // reset empties the buffer
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output buffer not empty after reset");

endmodule

bind debounced_tally_counter dtc_checker u_dtc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
